// ----- sv/pcmct_pkg.sv -----
// Package: sizes, codes and controller/datapath handshake types for the client counter table.
package pcmct_pkg;

  localparam int CAPACITY = 128;
  localparam int LANES    = 8;
  localparam int ROWS     = (CAPACITY + LANES - 1) / LANES;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W   = $clog2(LANES);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int ENTRY_W  = ADDR_W + PORT_W + COUNT_W;

  localparam logic KIND_MSG   = 1'b0;
  localparam logic KIND_LEAVE = 1'b1;

  typedef enum logic [2:0] {
    ST_COUNTED = 3'd0,
    ST_ADDED   = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_MISSED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic last_row;
    logic out_busy;
  } stat_t;

endpackage

// ----- sv/pcmct_req_if.sv -----
// Interface: request channel carrying one message or leave item.
interface pcmct_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] src_addr;
  logic [15:0] src_port;

  modport source (output valid, output kind, output src_addr, output src_port, input ready);
  modport sink   (input valid, input kind, input src_addr, input src_port, output ready);
endinterface

// ----- sv/pcmct_rsp_if.sv -----
// Interface: response channel carrying one result item.
interface pcmct_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] msg_total;
  logic [7:0]  entries_used;

  modport source (output valid, output status, output msg_total, output entries_used,
                  input ready);
  modport sink   (input valid, input status, input msg_total, input entries_used,
                  output ready);
endinterface

// ----- sv/per_client_message_counter_table.sv -----
// Top level: per-client message counter table, controller plus datapath.
// Each item passes accept, a scan that reads one RAM row of 8 entries per cycle, a drain
//   step and the update; the update waits while the previous result is not yet taken.
// One item is in flight at a time; a new item is accepted while the previous result still
//   waits in the output register.
// Reset (rst, synchronous, active high) clears the valid bits, the occupancy count and
//   the controller; entry RAM contents stay undefined and are only read behind valid bits.
module per_client_message_counter_table (
  input logic         clk,
  input logic         rst,
  pcmct_req_if.sink   req,
  pcmct_rsp_if.source rsp
);
  import pcmct_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: owns req.ready, issues load / scan / apply.
  pcmct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: lane RAMs hold {addr, port, count}; valid bits live in flops.
  pcmct_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_kind  (req.kind),
    .req_addr  (req.src_addr),
    .req_port  (req.src_port),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_status(rsp.status),
    .rsp_total (rsp.msg_total),
    .rsp_used  (rsp.entries_used)
  );

  // One item in flight: no accept in the cycle right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("item accepted while previous item still scanning");

  // Drops, removals and missed leaves report a zero total.
  a_zero_total: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_FULL || rsp.status == ST_REMOVED ||
                  rsp.status == ST_MISSED) |-> rsp.msg_total == 32'd0)
    else $error("nonzero total on drop or removal");

  // A new client starts at one.
  a_added_one: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_ADDED |-> rsp.msg_total == 32'd1)
    else $error("new client total not one");

  // Occupancy never exceeds the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (CAPACITY > 255) || (int'(rsp.entries_used) <= CAPACITY))
    else $error("entries_used beyond capacity");
endmodule

// ----- sv/pcmct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pcmct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/pcmct_ctrl.sv -----
// Controller: sequences accept, row scan, drain and table update for each item.
module pcmct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  pcmct_pkg::stat_t stat,
  output pcmct_pkg::cmd_t  cmd
);
  import pcmct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.last_row) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_DRAIN: begin
      end
      S_APPLY: begin
        cmd.apply = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end
endmodule

// ----- sv/pcmct_dpath.sv -----
// Datapath: entry RAM lanes, valid bits, row compare, update and result register.
module pcmct_dpath (
  input  logic             clk,
  input  logic             rst,
  input  pcmct_pkg::cmd_t  cmd,
  output pcmct_pkg::stat_t stat,
  input  logic             req_kind,
  input  logic [31:0]      req_addr,
  input  logic [15:0]      req_port,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [2:0]       rsp_status,
  output logic [31:0]      rsp_total,
  output logic [7:0]       rsp_used
);
  import pcmct_pkg::*;

  // held key
  logic              key_kind;
  logic [ADDR_W-1:0] key_addr;
  logic [PORT_W-1:0] key_port;

  // scan pointers
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] cmp_row;
  logic             cmp_live;

  // scan findings
  logic               hit_found;
  logic [ROW_W-1:0]   hit_row;
  logic [LANE_W-1:0]  hit_lane;
  logic [COUNT_W-1:0] hit_count;
  logic               free_found;
  logic [ROW_W-1:0]   free_row;
  logic [LANE_W-1:0]  free_lane;

  logic             valid_bits [ROWS][LANES];
  logic [CNT_W-1:0] used_total;

  logic [ENTRY_W-1:0] rd_data [LANES];

  // compare results for the row now on the RAM outputs
  logic               row_hit;
  logic [LANE_W-1:0]  row_hit_lane;
  logic [COUNT_W-1:0] row_hit_count;
  logic               row_free;
  logic [LANE_W-1:0]  row_free_lane;

  // write port
  logic               wr_en;
  logic [ROW_W-1:0]   wr_row;
  logic [LANE_W-1:0]  wr_lane;
  logic [ENTRY_W-1:0] wr_data;
  logic [COUNT_W-1:0] count_inc;

  assign stat.last_row = (row == ROW_W'(ROWS - 1));
  assign stat.out_busy = rsp_valid && !rsp_ready;

  assign count_inc = (hit_count == '1) ? hit_count : hit_count + COUNT_W'(1);
  assign wr_en     = cmd.apply && (key_kind == KIND_MSG) && (hit_found || free_found);
  assign wr_row    = hit_found ? hit_row  : free_row;
  assign wr_lane   = hit_found ? hit_lane : free_lane;
  assign wr_data   = {key_addr, key_port, hit_found ? count_inc : COUNT_W'(1)};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pcmct_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en && (wr_lane == LANE_W'(l))),
      .waddr(wr_row),
      .wdata(wr_data),
      .raddr(row),
      .rdata(rd_data[l])
    );
  end

  always_comb begin
    logic in_range;
    row_hit       = 1'b0;
    row_hit_lane  = '0;
    row_hit_count = '0;
    row_free      = 1'b0;
    row_free_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      in_range = (int'(cmp_row) * LANES + l) < CAPACITY;
      if (cmp_live && in_range && valid_bits[cmp_row][l] &&
          rd_data[l][ENTRY_W-1 -: ADDR_W] == key_addr &&
          rd_data[l][COUNT_W +: PORT_W] == key_port) begin
        row_hit       = 1'b1;
        row_hit_lane  = LANE_W'(l);
        row_hit_count = rd_data[l][COUNT_W-1:0];
      end
      // descending loop leaves the lowest free lane
      if (cmp_live && in_range && !valid_bits[cmp_row][l]) begin
        row_free      = 1'b1;
        row_free_lane = LANE_W'(l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_kind <= req_kind;
      key_addr <= req_addr;
      key_port <= req_port;
    end
    if (cmd.scan) begin
      cmp_row <= row;
    end
    if (row_hit) begin
      hit_row   <= cmp_row;
      hit_lane  <= row_hit_lane;
      hit_count <= row_hit_count;
    end
    if (row_free && !free_found) begin
      free_row  <= cmp_row;
      free_lane <= row_free_lane;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      cmp_live   <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_live <= cmd.scan;
      if (cmd.load) begin
        row        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.scan) row <= row + ROW_W'(1);
        if (row_hit)  hit_found  <= 1'b1;
        if (row_free) free_found <= 1'b1;
      end
    end
  end

  // valid bits, occupancy and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      used_total <= '0;
      rsp_valid  <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        for (int l = 0; l < LANES; l++) begin
          valid_bits[r][l] <= 1'b0;
        end
      end
    end else begin
      if (cmd.apply) begin
        rsp_valid <= 1'b1;
        if (key_kind == KIND_LEAVE) begin
          if (hit_found) begin
            valid_bits[hit_row][hit_lane] <= 1'b0;
            if (used_total != '0) used_total <= used_total - CNT_W'(1);
          end
        end else if (!hit_found && free_found) begin
          valid_bits[free_row][free_lane] <= 1'b1;
          used_total <= used_total + CNT_W'(1);
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (key_kind == KIND_LEAVE) begin
        rsp_total <= '0;
        if (hit_found) begin
          rsp_status <= ST_REMOVED;
          rsp_used   <= 8'(used_total - ((used_total != '0) ? CNT_W'(1) : CNT_W'(0)));
        end else begin
          rsp_status <= ST_MISSED;
          rsp_used   <= 8'(used_total);
        end
      end else if (hit_found) begin
        rsp_status <= ST_COUNTED;
        rsp_total  <= count_inc;
        rsp_used   <= 8'(used_total);
      end else if (free_found) begin
        rsp_status <= ST_ADDED;
        rsp_total  <= COUNT_W'(1);
        rsp_used   <= 8'(used_total + CNT_W'(1));
      end else begin
        rsp_status <= ST_FULL;
        rsp_total  <= '0;
        rsp_used   <= 8'(used_total);
      end
    end
  end
endmodule
